// ===== hw/rtl/crcdc_pkg.sv =====
// Shared types, constants and the CRC32C byte update for the content-defined chunker.
package crcdc_pkg;

   // CRC32C (Castagnoli), reflected form
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

   // Register indexes on the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SUB_SIZE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SUB_SIZE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_MASK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBS_PER_CHUNK = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STREAM_LENGTH  = 3'd4;

   // Register reset values
   localparam logic [15:0] MIN_SUB_SIZE_RESET   = 16'd2048;
   localparam logic [15:0] MAX_SUB_SIZE_RESET   = 16'd8192;
   localparam logic [31:0] STOP_MASK_RESET      = 32'h0000_0FFF;
   localparam logic [7:0]  SUBS_PER_CHUNK_RESET = 8'd8;

   // Packed result widths
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned CSR_DATA_W = 32;

   // One result: a closed sub-chunk
   typedef struct packed {
      logic [15:0] sub_size;
      logic [31:0] signature;
      logic [7:0]  sub_index;
      logic        chunk_end;
      logic        stream_end;
   } rsp_item_type;

   // Fold one byte into a running CRC32C
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/crcdc_result_buffer.sv =====
// Two-entry result buffer: output register plus skid register.
module crcdc_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  crcdc_pkg::rsp_item_type push_item,
   output logic                  has_room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output crcdc_pkg::rsp_item_type out_item
);

   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   crcdc_pkg::rsp_item_type out_item_ff, out_item_in;
   crcdc_pkg::rsp_item_type skid_item_ff, skid_item_in;
   logic                    pop;

   assign pop = out_valid_ff && out_ready;

   // Fill order: output register first, skid only when the output is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_item_in  = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign has_room  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== hw/rtl/crc32c_content_defined_chunker.sv =====
// Top level of the CRC32C content-defined chunker.
// One data byte is taken per request, one per clock while the two-entry result buffer
// has room; the CRC32C byte update, the boundary test against stop_mask and the
// counters all settle combinationally, so a steady stream runs at one byte per clock.
// A boundary result leaves through the output register; the skid entry holds one more
// result while that one stalls; requests stop once both are full. Requests are held off
// in a cycle that offers a register write. Writing stream_length starts a new stream.
// Bytes past the end of the stream are taken and dropped.
module crc32c_content_defined_chunker #(
   parameter int unsigned CHECK_STEP = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel, tdata: data_byte[7:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: sub_size[15:0], signature[47:16], sub_index[55:48]
   output logic [crcdc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,   // chunk_end
   output logic                                  rsp_tuser,   // stream_end
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crcdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crcdc_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Size phase modulo CHECK_STEP
   localparam int unsigned MOD_W = $clog2(CHECK_STEP + 1);
   localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(CHECK_STEP - 1);
   localparam logic [MOD_W-1:0] MIN_MOD_RESET =
      MOD_W'(crcdc_pkg::MIN_SUB_SIZE_RESET % CHECK_STEP);
   // Reciprocal for a 16-bit value modulo CHECK_STEP (exact up to 16)
   localparam int unsigned RECIP_SHIFT = 21;
   localparam logic [21:0] RECIP = 22'((32'd1 << RECIP_SHIFT) / CHECK_STEP + 1);

   function automatic logic [MOD_W-1:0] mod_step(input logic [15:0] d);
      logic [37:0] prod;
      logic [15:0] quot;
      logic [15:0] back;
      prod = {22'd0, d} * {16'd0, RECIP};
      quot = prod[RECIP_SHIFT+15:RECIP_SHIFT];
      back = 16'(quot * CHECK_STEP);
      return MOD_W'(d - back);
   endfunction

   // Configuration
   logic [15:0]      min_ff;
   logic [15:0]      max_ff;
   logic [31:0]      mask_ff;
   logic [7:0]       subs_ff;
   logic [MOD_W-1:0] min_mod_ff;

   // Stream state
   logic [31:0]      crc_ff, crc_in;
   logic [15:0]      count_ff, count_in;
   logic [MOD_W-1:0] mod_ff, mod_in;
   logic [7:0]       position_ff, position_in;
   logic [31:0]      left_ff, left_in;
   logic             tail_ff, tail_in;

   logic             csr_write;
   logic             accept;
   logic             has_room;
   logic             push;
   crcdc_pkg::rsp_item_type push_item;
   crcdc_pkg::rsp_item_type out_item;

   logic [15:0]      eff_max;
   logic             tail_now;
   logic [31:0]      crc_new;
   logic [31:0]      sig;
   logic [15:0]      count_new;
   logic [31:0]      left_new;
   logic [MOD_W-1:0] mod_new;
   logic             check_hit;
   logic             sub_end;
   logic             stream_end;
   logic             chunk_end;
   logic [8:0]       position_next;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = has_room && !csr_valid;
   assign accept     = req_tvalid && req_tready;

   // One byte: CRC update, counters and boundary decision
   always_comb begin
      eff_max       = (max_ff == 16'd0) ? 16'd1 : max_ff;
      tail_now      = (count_ff == 16'd0) ? (left_ff < {16'd0, eff_max}) : tail_ff;
      crc_new       = crcdc_pkg::crc32c_byte(crc_ff, req_tdata);
      sig           = ~crc_new;
      count_new     = count_ff + 16'd1;
      left_new      = left_ff - 32'd1;
      mod_new       = (mod_ff == MOD_LAST) ? '0 : mod_ff + 1'b1;
      check_hit     = (count_new >= min_ff) && (mod_new == min_mod_ff) &&
                      ((sig & mask_ff) == 32'd0);
      stream_end    = (left_new == 32'd0);
      sub_end       = tail_now ? stream_end : (check_hit || (count_new >= eff_max));
      position_next = {1'b0, position_ff} + 9'd1;
      chunk_end     = stream_end || (position_next >= {1'b0, subs_ff});

      push_item.sub_size   = count_new;
      push_item.signature  = sig;
      push_item.sub_index  = position_ff;
      push_item.chunk_end  = chunk_end;
      push_item.stream_end = stream_end;
      push = accept && (left_ff != 32'd0) && sub_end;

      crc_in      = crc_ff;
      count_in    = count_ff;
      mod_in      = mod_ff;
      position_in = position_ff;
      left_in     = left_ff;
      tail_in     = tail_ff;
      if (accept && (left_ff != 32'd0)) begin
         left_in = left_new;
         if (sub_end) begin
            crc_in      = crcdc_pkg::CRC_INIT;
            count_in    = 16'd0;
            mod_in      = '0;
            tail_in     = 1'b0;
            position_in = chunk_end ? 8'd0 : position_next[7:0];
         end else begin
            crc_in   = crc_new;
            count_in = count_new;
            mod_in   = mod_new;
            tail_in  = tail_now;
         end
      end
   end

   // Registers; a stream_length write restarts the stream
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= crcdc_pkg::MIN_SUB_SIZE_RESET;
         max_ff      <= crcdc_pkg::MAX_SUB_SIZE_RESET;
         mask_ff     <= crcdc_pkg::STOP_MASK_RESET;
         subs_ff     <= crcdc_pkg::SUBS_PER_CHUNK_RESET;
         min_mod_ff  <= MIN_MOD_RESET;
         crc_ff      <= crcdc_pkg::CRC_INIT;
         count_ff    <= 16'd0;
         mod_ff      <= '0;
         position_ff <= 8'd0;
         left_ff     <= 32'd0;
         tail_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            crcdc_pkg::CSR_MIN_SUB_SIZE: begin
               min_ff     <= csr_data[15:0];
               min_mod_ff <= mod_step(csr_data[15:0]);
            end
            crcdc_pkg::CSR_MAX_SUB_SIZE:   max_ff  <= csr_data[15:0];
            crcdc_pkg::CSR_STOP_MASK:      mask_ff <= csr_data;
            crcdc_pkg::CSR_SUBS_PER_CHUNK: subs_ff <= csr_data[7:0];
            crcdc_pkg::CSR_STREAM_LENGTH: begin
               crc_ff      <= crcdc_pkg::CRC_INIT;
               count_ff    <= 16'd0;
               mod_ff      <= '0;
               position_ff <= 8'd0;
               left_ff     <= csr_data;
               tail_ff     <= 1'b0;
            end
            default: ;
         endcase
      end else begin
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         mod_ff      <= mod_in;
         position_ff <= position_in;
         left_ff     <= left_in;
         tail_ff     <= tail_in;
      end
   end

   // Result buffer
   crcdc_result_buffer u_result_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {out_item.sub_index, out_item.signature, out_item.sub_size};
   assign rsp_tlast = out_item.chunk_end;
   assign rsp_tuser = out_item.stream_end;

endmodule

// ===== hw/rtl/crcdc_checker.sv =====
// Port-level checks on the chunker's result channel, bound to the top level.
module crcdc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [crcdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // end of stream always closes the chunk
   a_stream_closes_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end without chunk end");

   // a sub-chunk holds at least one byte
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'd0)
      else $error("zero sub-chunk size");

   // sub-chunk position never reaches 255
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:48] != 8'hFF)
      else $error("sub index out of range");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind crc32c_content_defined_chunker crcdc_checker u_crcdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
